FILE: hw/rtl/boad_pkg.sv
// Shared types and constants for the boot overlay address decoder.
// Used by boad_decode and boot_overlay_address_decoder_core; depends on nothing.
package boad_pkg;

	// Bus commands carried with each input word
	typedef enum logic [1:0] {
		CMD_READ      = 2'd0,
		CMD_WRITE     = 2'd1,
		CMD_BUS_RESET = 2'd2
	} cmd_t;

	// Decoded targets
	typedef enum logic [3:0] {
		TGT_NONE   = 4'd0,
		TGT_ROM    = 4'd1,
		TGT_DRAM   = 4'd2,
		TGT_SRAM   = 4'd3,
		TGT_IDE2   = 4'd4,
		TGT_FLOPPY = 4'd5,
		TGT_SDPORT = 4'd6,
		TGT_IRQCTL = 4'd7,
		TGT_CFG    = 4'd8,
		TGT_RTC    = 4'd9,
		TGT_IDE1   = 4'd10,
		TGT_UART   = 4'd11
	} target_t;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned OFFSET_W = 28;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned RAM_MB_W = 9;

	// Installed DRAM size after reset, in MB
	localparam logic [RAM_MB_W-1:0] RAM_SIZE_RESET = 9'd256;
	// At or below this size the hole starts at 64MB
	localparam logic [RAM_MB_W-1:0] SMALL_RAM_MB   = 9'd64;

	// Region boundaries of the upper address space
	localparam logic [ADDR_W-1:0] ROM_BASE   = 32'hFFF0_0000;
	localparam logic [ADDR_W-1:0] ROM_END    = 32'hFFF8_0000;
	localparam logic [ADDR_W-1:0] SRAM_BASE  = 32'hFFFE_0000;
	localparam logic [ADDR_W-1:0] IO_BASE    = 32'hFFFF_0000;

	// One input word
	typedef struct packed {
		logic                debug_read;
		logic [BYTE_W-1:0]   write_byte;
		logic [ADDR_W-1:0]   address;
		cmd_t                command;
	} item_t;

	// One result word, packed lowest field last
	typedef struct packed {
		logic                overlay_active;
		logic                bus_error;
		logic                floating_read;
		logic [BYTE_W-1:0]   data_out;
		logic                write_enable;
		logic [OFFSET_W-1:0] offset;
		target_t             target;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

	typedef struct packed {
		target_t             target;
		logic [OFFSET_W-1:0] offset;
	} io_sel_t;

	// Decode the low address byte of the I/O page
	function automatic io_sel_t io_decode(input logic [ADDR_W-1:0] a);
		io_sel_t sel;
		sel.target = TGT_NONE;
		sel.offset = '0;
		case (a[7:0]) inside
			[8'h20:8'h2F]: begin
				sel.target = TGT_IDE2;
				sel.offset = OFFSET_W'(a[1:0]);
			end
			[8'h30:8'h3F]: begin
				sel.target = TGT_FLOPPY;
				sel.offset = OFFSET_W'(a[3:0]);
			end
			8'h08, 8'h09: begin
				sel.target = TGT_SDPORT;
				sel.offset = OFFSET_W'(a[0]);
			end
			8'h40: begin
				sel.target = TGT_IRQCTL;
				sel.offset = OFFSET_W'(a[15:0]);
			end
			8'h42: sel.target = TGT_CFG;
			8'h43: sel.target = TGT_RTC;
			[8'h44:8'h47]: begin
				sel.target = TGT_IDE1;
				sel.offset = OFFSET_W'(a[1:0]);
			end
			[8'h48:8'h4F]: begin
				sel.target = TGT_UART;
				sel.offset = OFFSET_W'(a[2:0]);
			end
			default: sel.target = TGT_NONE;
		endcase
		return sel;
	endfunction

endpackage

FILE: hw/rtl/boot_overlay_address_decoder_core.sv
// Top level of the boot overlay address decoder: input register, decode, result register.
// Depends on boad_pkg and boad_decode.
//
// Usage: each slave-side word is one CPU byte access (read, write or bus reset);
// each master-side word is its decoded result (target, offset, write enable,
// forwarded byte, floating read, bus error, boot overlay flag). Exactly one
// result word leaves for every accepted word, in order.
// A word accepted into the input register is decoded and then held in the result register, which drives m_tvalid.
// Throughput: one word per cycle unless the receiver stalls; the boot shift register is
// the only state carried from one access to the next and updates in the decode cycle.
// A stalled receiver holds the result register; the input register still
// takes a word while the result waits, and s_tready drops only when both
// stages are full.
// cfg_we/cfg_wdata write the installed DRAM size in MB; write it only while
// no word is in flight.
// Reset: both stages empty, boot shift register zero (reads go to ROM and writes
// are dropped until eight non-debug reads or writes have passed), DRAM size 256MB.
module boot_overlay_address_decoder_core #(
	parameter int unsigned ROM_BYTES  = 524288,
	parameter int unsigned SRAM_BYTES = 32768,
	parameter int unsigned MAX_RAM_MB = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // address[31:0], write_byte[39:32]
	input  logic [2:0]  s_tuser,   // command[1:0], debug_read[2]
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // target[3:0], offset[31:4], write_enable[32],
	                               // data_out[40:33], floating_read[41],
	                               // bus_error[42], overlay_active[43], zeros[47:44]
	// configuration
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata  // ram_size_mb
);

	logic                          valid_s1;
	boad_pkg::item_t               item_s1;
	logic                          valid_s2;
	boad_pkg::result_t             result_s2;
	logic [7:0]                    boot_shift_q;
	logic [boad_pkg::RAM_MB_W-1:0] ram_size_q;

	boad_pkg::result_t             result;
	logic [7:0]                    boot_shift_nxt;
	logic                          free_s2;
	logic                          adv_s1;
	logic                          acc_in;

	// Handshake between stages
	assign free_s2  = ~valid_s2 | m_tready;
	assign adv_s1   = valid_s1 & free_s2;
	assign s_tready = ~valid_s1 | free_s2;
	assign acc_in   = s_tvalid & s_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			item_s1.command    <= boad_pkg::cmd_t'(s_tuser[1:0]);
			item_s1.debug_read <= s_tuser[2];
			item_s1.address    <= s_tdata[31:0];
			item_s1.write_byte <= s_tdata[39:32];
		end
	end

	// Decode
	boad_decode #(
		.ROM_BYTES  (ROM_BYTES),
		.SRAM_BYTES (SRAM_BYTES),
		.MAX_RAM_MB (MAX_RAM_MB)
	) u_decode (
		.item           (item_s1),
		.boot_shift     (boot_shift_q),
		.ram_size_mb    (ram_size_q),
		.result         (result),
		.boot_shift_nxt (boot_shift_nxt)
	);

	// Advance boot shift register and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_shift_q <= '0;
			ram_size_q   <= boad_pkg::RAM_SIZE_RESET;
		end else begin
			if (adv_s1) begin
				boot_shift_q <= boot_shift_nxt;
			end
			if (cfg_we) begin
				ram_size_q <= cfg_wdata;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(48 - boad_pkg::RESULT_W)'(0), result_s2};

	// Checks

	// a forced boot access only ever reads ROM or drops the write
	a_overlay_target: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s2.overlay_active) |->
		(result_s2.target == boad_pkg::TGT_ROM || result_s2.target == boad_pkg::TGT_NONE))
		else $error("overlay access with unexpected target");

	// a write that reaches a target is never floating or in error
	a_we_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s2.write_enable) |->
		(!result_s2.floating_read && !result_s2.bus_error &&
		 result_s2.target != boad_pkg::TGT_NONE && !result_s2.overlay_active))
		else $error("write enable with floating, error or no target");

	// forwarded byte is zero unless the write goes through
	a_data_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !result_s2.write_enable) |-> (result_s2.data_out == '0))
		else $error("data forwarded without write enable");

	// a bus reset leaving the input stage clears the boot shift register
	a_bus_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.command == boad_pkg::CMD_BUS_RESET) |=> (boot_shift_q == 8'd0))
		else $error("boot shift register not cleared by bus reset");

endmodule

FILE: hw/rtl/boad_decode.sv
// Single-pass decode of one bus access plus next value of the boot shift register.
// Depends on boad_pkg.
module boad_decode #(
	parameter int unsigned ROM_BYTES  = 524288,
	parameter int unsigned SRAM_BYTES = 32768,
	parameter int unsigned MAX_RAM_MB = 256
) (
	input  boad_pkg::item_t                     item,
	input  logic [7:0]                          boot_shift,
	input  logic [boad_pkg::RAM_MB_W-1:0]       ram_size_mb,
	output boad_pkg::result_t                   result,
	output logic [7:0]                          boot_shift_nxt
);

	localparam int unsigned RomAw  = $clog2(ROM_BYTES);
	localparam int unsigned SramAw = $clog2(SRAM_BYTES);

	logic [boad_pkg::ADDR_W-1:0]   a;
	logic [boad_pkg::RAM_MB_W-1:0] mb_sat;
	logic                          booting;
	logic                          in_dram;
	logic                          in_hole;
	logic                          in_rom;
	logic                          in_empty;
	logic                          in_sram;
	logic                          hole_berr;
	logic [boad_pkg::OFFSET_W-1:0] rom_off;
	logic [boad_pkg::OFFSET_W-1:0] sram_off;
	boad_pkg::io_sel_t             io_sel;

	// Region flags, in priority order
	always_comb begin
		a        = item.address;
		mb_sat   = (ram_size_mb > boad_pkg::RAM_MB_W'(MAX_RAM_MB)) ?
			boad_pkg::RAM_MB_W'(MAX_RAM_MB) : ram_size_mb;
		booting  = ~boot_shift[7];
		// a below size * 1MB when its MB number is below size
		in_dram  = a[31:20] < 12'(mb_sat);
		in_hole  = a < boad_pkg::ROM_BASE;
		in_rom   = a < boad_pkg::ROM_END;
		in_empty = a < boad_pkg::SRAM_BASE;
		in_sram  = a < boad_pkg::IO_BASE;
		// DRAM is capped at MAX_RAM_MB (256MB by default); the 256MB rule always applies
		hole_berr = (a[31:28] != 4'd0) ||
			((mb_sat <= boad_pkg::SMALL_RAM_MB) && (a[31:26] != 6'd0));
		rom_off  = boad_pkg::OFFSET_W'(a[RomAw-1:0]);
		sram_off = boad_pkg::OFFSET_W'(a[SramAw-1:0]);
		io_sel   = boad_pkg::io_decode(a);
	end

	// Result and shift update
	always_comb begin
		result         = '0;
		result.target  = boad_pkg::TGT_NONE;
		boot_shift_nxt = boot_shift;
		case (item.command)
			boad_pkg::CMD_BUS_RESET: begin
				boot_shift_nxt = '0;
			end
			boad_pkg::CMD_READ: begin
				if (!item.debug_read) begin
					boot_shift_nxt = {boot_shift[6:0], 1'b1};
				end
				if (booting) begin
					result.target         = boad_pkg::TGT_ROM;
					result.offset         = rom_off;
					result.overlay_active = 1'b1;
				end else if (in_dram) begin
					result.target = boad_pkg::TGT_DRAM;
					result.offset = a[boad_pkg::OFFSET_W-1:0];
				end else if (in_hole) begin
					result.floating_read = 1'b1;
					result.bus_error     = hole_berr;
				end else if (in_rom) begin
					result.target = boad_pkg::TGT_ROM;
					result.offset = rom_off;
				end else if (in_empty) begin
					result.floating_read = 1'b1;
				end else if (in_sram) begin
					result.target = boad_pkg::TGT_SRAM;
					result.offset = sram_off;
				end else if (item.debug_read) begin
					result.floating_read = 1'b1;
				end else begin
					result.target        = io_sel.target;
					result.offset        = io_sel.offset;
					result.floating_read = (io_sel.target == boad_pkg::TGT_NONE);
				end
			end
			boad_pkg::CMD_WRITE: begin
				boot_shift_nxt = {boot_shift[6:0], 1'b1};
				if (booting) begin
					result.overlay_active = 1'b1;
				end else if (in_dram) begin
					result.target       = boad_pkg::TGT_DRAM;
					result.offset       = a[boad_pkg::OFFSET_W-1:0];
					result.write_enable = 1'b1;
				end else if (in_hole) begin
					result.bus_error = hole_berr;
				end else if (in_rom) begin
					result.target = boad_pkg::TGT_ROM;
					result.offset = rom_off;
				end else if (in_empty) begin
					result.target = boad_pkg::TGT_NONE;
				end else if (in_sram) begin
					result.target       = boad_pkg::TGT_SRAM;
					result.offset       = sram_off;
					result.write_enable = 1'b1;
				end else begin
					result.target       = io_sel.target;
					result.offset       = io_sel.offset;
					result.write_enable = (io_sel.target != boad_pkg::TGT_NONE);
				end
				result.data_out = result.write_enable ? item.write_byte : '0;
			end
			default: begin
				// unused command code: empty result, state kept
				boot_shift_nxt = boot_shift;
			end
		endcase
	end

endmodule
